/* rtl/stt_pkg.sv */
package stt_pkg;

    // Token kinds as they appear on the result stream
    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_OP      = 2'd1;
    localparam logic [1:0] KIND_BRACKET = 2'd2;
    localparam logic [1:0] KIND_STRING  = 2'd3;

    // Characters with a special role
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2a;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Most results one text byte can cause
    localparam int unsigned MAX_RES = 3;

    // One result beat
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       start;
        logic [1:0] kind;
    } stt_res_t;

    // All results of one text byte, handed from the scanner to the output buffer
    typedef struct packed {
        logic [1:0]             count;
        logic                   done;
        stt_res_t [MAX_RES-1:0] res;
    } stt_step_t;

    function automatic logic is_sep(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c inside {"(", ")", "[", "]", "{", "}"};
    endfunction

    function automatic logic is_opchar(input logic [7:0] c);
        return c inside {"+", "-", "*", "/", "%", "=", "!", "&", "|", ">", "<",
                         8'h5c, ":", ";", CH_QUOTE, 8'h27, "(", ")", "[", "]",
                         "{", "}", ".", ",", "?", "#"};
    endfunction

endpackage

/* rtl/stt_scan.sv */
module stt_scan
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] c,
    input  logic       eot,
    input  logic       lower_en,
    output stt_step_t  step
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_OPHOLD,
        MODE_OPSTREAM,
        MODE_STRING,
        MODE_LINECMT,
        MODE_BLOCKCMT
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] h0_reg, h0_next;
    logic [7:0] h1_reg, h1_next;
    logic [1:0] hc_reg, hc_next;
    logic       pws_reg, pws_next;

    logic                   c_sep, c_br, c_op, c_run;
    logic                   do_begin, do_cmt;
    logic [1:0]             n_v;
    stt_res_t [MAX_RES-1:0] res_v;

    assign c_sep = is_sep(c);
    assign c_br  = is_bracket(c);
    assign c_op  = is_opchar(c);
    assign c_run = c_op && !c_br;

    // Next state and results for one text byte
    always_comb
    begin
        mode_next = mode_reg;
        h0_next   = h0_reg;
        h1_next   = h1_reg;
        hc_next   = hc_reg;
        pws_next  = pws_reg;
        n_v       = '0;
        res_v     = '0;
        do_begin  = 1'b0;
        do_cmt    = 1'b0;

        case (mode_reg)
            MODE_WORD:
            begin
                if (!c_sep && !c_op)
                begin
                    res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b0, kind: KIND_WORD};
                    n_v = n_v + 2'd1;
                end
                else
                    do_begin = 1'b1;
            end
            MODE_STRING:
            begin
                res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b0, kind: KIND_STRING};
                n_v = n_v + 2'd1;
                if (c == CH_QUOTE)
                    mode_next = MODE_IDLE;
            end
            MODE_OPSTREAM:
            begin
                if (c_run)
                begin
                    res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b0, kind: KIND_OP};
                    n_v = n_v + 2'd1;
                end
                else
                    do_begin = 1'b1;
            end
            MODE_OPHOLD:
            begin
                if (c_run)
                begin
                    if (hc_reg < 2'd2)
                    begin
                        h1_next = c;
                        hc_next = 2'd2;
                    end
                    else
                    begin
                        // run is longer than two: release held bytes and stream
                        res_v[0]  = '{ch: h0_reg, valid: 1'b1, start: 1'b1, kind: KIND_OP};
                        res_v[1]  = '{ch: h1_reg, valid: 1'b1, start: 1'b0, kind: KIND_OP};
                        res_v[2]  = '{ch: c, valid: 1'b1, start: 1'b0, kind: KIND_OP};
                        n_v       = 2'd3;
                        hc_next   = '0;
                        mode_next = MODE_OPSTREAM;
                    end
                end
                else
                begin
                    // run ended: comment opener or plain operator token
                    if (hc_reg == 2'd2 && h0_reg == CH_SLASH && h1_reg == CH_SLASH)
                    begin
                        mode_next = MODE_LINECMT;
                        do_cmt    = 1'b1;
                    end
                    else if (hc_reg == 2'd2 && h0_reg == CH_SLASH && h1_reg == CH_STAR)
                    begin
                        mode_next = MODE_BLOCKCMT;
                        pws_next  = 1'b0;
                        do_cmt    = 1'b1;
                    end
                    else
                    begin
                        if (hc_reg >= 2'd1)
                        begin
                            res_v[n_v] = '{ch: h0_reg, valid: 1'b1, start: 1'b1,
                                           kind: KIND_OP};
                            n_v = n_v + 2'd1;
                        end
                        if (hc_reg >= 2'd2)
                        begin
                            res_v[n_v] = '{ch: h1_reg, valid: 1'b1, start: 1'b0,
                                           kind: KIND_OP};
                            n_v = n_v + 2'd1;
                        end
                        do_begin = 1'b1;
                    end
                    hc_next = '0;
                end
            end
            MODE_LINECMT, MODE_BLOCKCMT:
                do_cmt = 1'b1;
            default:
                do_begin = 1'b1;
        endcase

        // Comment body byte
        if (do_cmt)
        begin
            if (mode_next == MODE_LINECMT)
            begin
                if (c == CH_LF)
                    mode_next = MODE_IDLE;
            end
            else if (pws_next && c == CH_SLASH)
            begin
                mode_next = MODE_IDLE;
                pws_next  = 1'b0;
            end
            else
                pws_next = (c == CH_STAR);
        end

        // First byte of a new token
        if (do_begin)
        begin
            mode_next = MODE_IDLE;
            if (c_br)
            begin
                res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b1, kind: KIND_BRACKET};
                n_v = n_v + 2'd1;
            end
            else if (c == CH_QUOTE)
            begin
                res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b1, kind: KIND_STRING};
                n_v = n_v + 2'd1;
                mode_next = MODE_STRING;
            end
            else if (c_op)
            begin
                h0_next   = c;
                hc_next   = 2'd1;
                mode_next = MODE_OPHOLD;
            end
            else if (!c_sep)
            begin
                res_v[n_v] = '{ch: c, valid: 1'b1, start: 1'b1, kind: KIND_WORD};
                n_v = n_v + 2'd1;
                mode_next = MODE_WORD;
            end
        end

        // End of text: flush a held run, return to idle
        if (eot)
        begin
            if (mode_next == MODE_OPHOLD &&
                !(hc_next == 2'd2 && h0_next == CH_SLASH &&
                  (h1_next == CH_SLASH || h1_next == CH_STAR)))
            begin
                if (hc_next >= 2'd1)
                begin
                    res_v[n_v] = '{ch: h0_next, valid: 1'b1, start: 1'b1, kind: KIND_OP};
                    n_v = n_v + 2'd1;
                end
                if (hc_next >= 2'd2)
                begin
                    res_v[n_v] = '{ch: h1_next, valid: 1'b1, start: 1'b0, kind: KIND_OP};
                    n_v = n_v + 2'd1;
                end
            end
            mode_next = MODE_IDLE;
            hc_next   = '0;
            pws_next  = 1'b0;
            // bare end marker when nothing else went out
            if (n_v == 2'd0)
                n_v = 2'd1;
        end

        // Lower-case A-Z outside strings when lower_en is set
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (lower_en && res_v[i].valid && res_v[i].kind != KIND_STRING &&
                res_v[i].ch inside {[CH_UC_A:CH_UC_Z]})
                res_v[i].ch = res_v[i].ch + CASE_OFS;
        end
    end

    assign step.count = n_v;
    assign step.done  = eot;
    assign step.res   = res_v;

    // Scanner state, advanced on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            hc_reg   <= '0;
            pws_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            hc_reg   <= hc_next;
            pws_reg  <= pws_next;
        end
    end

    // Held operator bytes carry no reset
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end

endmodule

/* rtl/source_text_tokenizer.sv */
// Channel   | Dir | Beat contents
// s_*       | in  | tdata[7:0] text_byte; tlast end_of_text
// m_*       | out | tdata[7:0] token_char; tlast last_result;
//           |     | tuser[0] char_valid, [1] token_start, [3:2] token_kind, [4] text_done
// cfg_*     | in  | cfg_wr_data lower_case_enable, written when cfg_wr_en is high
//
// A text byte is scanned in the cycle it is accepted and its 0 to 3 result beats are
// loaded into a three-entry result register; they leave one beat per cycle while
// m_tready is high. A byte is taken when the register is empty or its last beat
// leaves, so with m_tready high bytes of at most one result flow one per cycle and a
// byte of 2 or 3 results stalls input until its last beat leaves. Reset (rst_n low,
// async) empties the register, sets the scanner idle, clears lower_case_enable.
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,    // lower_case_enable
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,        // [7:0] text_byte
    input  logic       s_tlast,        // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,        // [7:0] token_char
    output logic       m_tlast,        // last_result
    output logic [4:0] m_tuser         // [0] char_valid, [1] token_start,
                                       // [3:2] token_kind, [4] text_done
);

    logic                   lower_en_reg;
    stt_res_t [MAX_RES-1:0] buf_reg;
    logic [1:0]             left_reg;
    logic [1:0]             rd_reg;
    logic                   done_reg;

    stt_step_t step;
    stt_res_t  cur;
    logic      s_fire, m_fire;

    assign m_tvalid = (left_reg != 2'd0);
    assign s_tready = (left_reg == 2'd0) || (left_reg == 2'd1 && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    stt_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s_fire),
        .c        (s_tdata),
        .eot      (s_tlast),
        .lower_en (lower_en_reg),
        .step     (step)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lower_en_reg <= 1'b0;
        else if (cfg_wr_en)
            lower_en_reg <= cfg_wr_data;
    end

    // Result register control: load on a new byte, else count down beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            rd_reg   <= '0;
            done_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            left_reg <= step.count;
            rd_reg   <= '0;
            done_reg <= step.done;
        end
        else if (m_fire)
        begin
            left_reg <= left_reg - 2'd1;
            rd_reg   <= rd_reg + 2'd1;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
            buf_reg <= step.res;
    end

    // Output beat
    always_comb
    begin
        case (rd_reg)
            2'd0:    cur = buf_reg[0];
            2'd1:    cur = buf_reg[1];
            2'd2:    cur = buf_reg[2];
            default: cur = buf_reg[0];
        endcase
    end

    assign m_tdata = cur.ch;
    assign m_tlast = (left_reg == 2'd1);
    assign m_tuser = {done_reg && (left_reg == 2'd1), cur.kind, cur.start, cur.valid};

    // A byte is only taken when at most the last beat is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |-> (left_reg <= 2'd1))
        else $error("byte accepted over pending results");

    // End of text always yields at least one beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_tlast) |=> m_tvalid)
        else $error("end of text produced no beat");

    // text_done only on the last beat of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[4]) |-> m_tlast)
        else $error("text_done away from last beat");

    // A bare end marker only closes the text
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tuser[4] && m_tlast && !m_tuser[1]))
        else $error("bare marker outside end of text");

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int RANDOM_BYTES = 200;
    localparam int CFG_SETTLE   = 4;     // quiet cycles before a register write
    localparam int DRAIN_CYCLES = 8;
    localparam int STUCK_LIMIT  = 1000;  // cycles with no beat while work is pending

    localparam logic [7:0] GAPS [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

    // Scanner modes of the predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_WORD,
        SCAN_OPHOLD,
        SCAN_OPRUN,
        SCAN_STRING,
        SCAN_LINE_CMT,
        SCAN_BLOCK_CMT
    } scan_state_t;

    // One expected result beat
    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       start;
        logic [1:0] kind;
        logic       last;
        logic       done;
    } token_beat_t;

    // One pending stimulus entry: a text byte or a register write
    typedef struct {
        bit         is_cfg;
        bit         cfg_val;
        logic [7:0] ch;
        bit         eot;
    } text_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;     // [7:0] text_byte
    logic       s_tlast = 1'b0;      // end_of_text
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;             // [7:0] token_char
    logic       m_tlast;             // last_result
    logic [4:0] m_tuser;             // [0] char_valid, [1] token_start,
                                     // [3:2] token_kind, [4] text_done

    text_item_t  text_q [$];
    token_beat_t token_beats_q [$];

    // Predictor state
    scan_state_t scan_st = SCAN_IDLE;
    logic [7:0]  held_ops [2] = '{8'h00, 8'h00};
    logic [1:0]  held_n = 2'd0;
    logic        star_seen = 1'b0;
    logic        lc_shadow = 1'b0;
    token_beat_t step_beats [MAX_RES];
    int          step_n;

    int err_cnt = 0;
    int n_queued = 0;
    int n_bytes_in = 0;
    int n_texts = 0;
    int n_lc_bytes = 0;
    int n_beats_out = 0;
    int n_cfg = 0;
    int quiet_cnt = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_cyc = 0;
    int stall_mode = 0;
    logic [7:0] stall_pat = 8'hff;
    int stuck_cnt = 0;
    token_beat_t want_beat;

    source_text_tokenizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Character classes
    // ------------------------------------------------------------------
    function automatic logic is_gap_ch(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_bracket_ch(logic [7:0] c);
        case (c)
            "(", ")", "[", "]", "{", "}": return 1'b1;
            default:                      return 1'b0;
        endcase
    endfunction

    function automatic logic is_op_ch(logic [7:0] c);
        case (c)
            "+", "-", "*", "/", "%", "=", "!", "&", "|", ">", "<", "\\", ":", ";",
            CH_QUOTE, 8'h27, ".", ",", "?", "#":
                return 1'b1;
            default:
                return is_bracket_ch(c);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic void put_char(logic [7:0] c, logic first, logic [1:0] kind);
        if (step_n >= MAX_RES)
            return;
        if (lc_shadow && kind != KIND_STRING && c >= CH_UC_A && c <= CH_UC_Z)
            c = c + CASE_OFS;
        step_beats[step_n] = '{c, 1'b1, first, kind, 1'b0, 1'b0};
        step_n++;
    endfunction

    function automatic void open_token(logic [7:0] c);
        scan_st = SCAN_IDLE;
        if (is_gap_ch(c))
            return;
        if (is_bracket_ch(c))
            put_char(c, 1'b1, KIND_BRACKET);
        else if (c == CH_QUOTE)
        begin
            put_char(c, 1'b1, KIND_STRING);
            scan_st = SCAN_STRING;
        end
        else if (is_op_ch(c))
        begin
            held_ops[0] = c;
            held_n = 2'd1;
            scan_st = SCAN_OPHOLD;
        end
        else
        begin
            put_char(c, 1'b1, KIND_WORD);
            scan_st = SCAN_WORD;
        end
    endfunction

    // Held run has ended: either a comment opener or a short operator token
    function automatic void settle_held();
        if (held_n == 2'd2 && held_ops[0] == CH_SLASH && held_ops[1] == CH_SLASH)
            scan_st = SCAN_LINE_CMT;
        else if (held_n == 2'd2 && held_ops[0] == CH_SLASH && held_ops[1] == CH_STAR)
        begin
            scan_st = SCAN_BLOCK_CMT;
            star_seen = 1'b0;
        end
        else
        begin
            if (held_n >= 2'd1)
                put_char(held_ops[0], 1'b1, KIND_OP);
            if (held_n >= 2'd2)
                put_char(held_ops[1], 1'b0, KIND_OP);
            scan_st = SCAN_IDLE;
        end
        held_n = 2'd0;
    endfunction

    function automatic void comment_char(logic [7:0] c);
        if (scan_st == SCAN_LINE_CMT)
        begin
            if (c == CH_LF)
                scan_st = SCAN_IDLE;
        end
        else if (star_seen && c == CH_SLASH)
        begin
            scan_st = SCAN_IDLE;
            star_seen = 1'b0;
        end
        else
            star_seen = (c == CH_STAR);
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        logic run_ch;
        run_ch = is_op_ch(c) && !is_bracket_ch(c);
        case (scan_st)
            SCAN_WORD:
                if (!is_gap_ch(c) && !is_op_ch(c))
                    put_char(c, 1'b0, KIND_WORD);
                else
                    open_token(c);
            SCAN_STRING:
            begin
                put_char(c, 1'b0, KIND_STRING);
                if (c == CH_QUOTE)
                    scan_st = SCAN_IDLE;
            end
            SCAN_OPRUN:
                if (run_ch)
                    put_char(c, 1'b0, KIND_OP);
                else
                    open_token(c);
            SCAN_OPHOLD:
                if (run_ch)
                begin
                    if (held_n < 2'd2)
                    begin
                        held_ops[1] = c;
                        held_n = 2'd2;
                    end
                    else
                    begin
                        // third run char: the run can no longer be a comment opener
                        put_char(held_ops[0], 1'b1, KIND_OP);
                        put_char(held_ops[1], 1'b0, KIND_OP);
                        put_char(c, 1'b0, KIND_OP);
                        held_n = 2'd0;
                        scan_st = SCAN_OPRUN;
                    end
                end
                else
                begin
                    settle_held();
                    if (scan_st == SCAN_LINE_CMT || scan_st == SCAN_BLOCK_CMT)
                        comment_char(c);
                    else
                        open_token(c);
                end
            SCAN_LINE_CMT, SCAN_BLOCK_CMT:
                comment_char(c);
            default:
                open_token(c);
        endcase
    endfunction

    // Work out every result beat of one accepted text byte
    function automatic void predict_token_beats(logic [7:0] c, logic eot);
        int i;
        step_n = 0;
        absorb_char(c);
        if (eot)
        begin
            if (scan_st == SCAN_OPHOLD)
                settle_held();
            scan_st = SCAN_IDLE;
            held_n = 2'd0;
            star_seen = 1'b0;
            // nothing emitted: a bare end marker
            if (step_n == 0)
            begin
                step_beats[0] = '0;
                step_n = 1;
            end
            step_beats[step_n-1].done = 1'b1;
        end
        if (step_n > 0)
            step_beats[step_n-1].last = 1'b1;
        for (i = 0; i < step_n; i++)
            token_beats_q.insert(token_beats_q.size(), step_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_byte(logic [7:0] c);
        text_q.insert(text_q.size(), text_item_t'{1'b0, 1'b0, c, 1'b0});
        n_queued++;
    endfunction

    function automatic void push_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endfunction

    function automatic void mark_end();
        text_q[text_q.size()-1].eot = 1'b1;
    endfunction

    function automatic void push_cfg(bit v);
        text_q.insert(text_q.size(), text_item_t'{1'b1, v, 8'h00, 1'b0});
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] word_ch();
        logic [7:0] c;
        case ($urandom_range(0, 3))
            0:       c = CH_UC_A + 8'($urandom_range(0, 25));
            1:       c = CH_UC_A + CASE_OFS + 8'($urandom_range(0, 25));
            2:       c = pick("0123456789_$@`~^");
            default:
            begin
                c = 8'($urandom_range(0, 255));
                while (is_gap_ch(c) || is_op_ch(c))
                    c = 8'($urandom_range(0, 255));
            end
        endcase
        return c;
    endfunction

    function automatic logic [7:0] any_but(logic [7:0] bad);
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == bad)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // Mostly well-formed tokens and comments, with some raw noise bytes
    function automatic void add_text(int n_pieces);
        int i;
        int j;
        for (i = 0; i < n_pieces; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    for (j = $urandom_range(1, 6); j > 0; j--)
                        push_byte(word_ch());
                2:
                    push_byte(GAPS[$urandom_range(0, 3)]);
                3:
                    push_byte(pick("()[]{}"));
                4:
                    for (j = $urandom_range(1, 4); j > 0; j--)
                        push_byte(pick("+-*/%=!&|><\\:;'.,?#"));
                5:
                begin
                    push_byte(CH_QUOTE);
                    for (j = $urandom_range(0, 5); j > 0; j--)
                        push_byte($urandom_range(0, 1) ? word_ch() : any_but(CH_QUOTE));
                    if ($urandom_range(0, 7) != 0)
                        push_byte(CH_QUOTE);
                end
                6:
                begin
                    push_text("//");
                    push_byte($urandom_range(0, 3) != 0 ? word_ch() : CH_SPACE);
                    for (j = $urandom_range(0, 5); j > 0; j--)
                        push_byte(any_but(CH_LF));
                    push_byte(CH_LF);
                end
                7:
                begin
                    push_text("/*");
                    push_byte($urandom_range(0, 1) ? word_ch() : CH_LF);
                    for (j = $urandom_range(0, 6); j > 0; j--)
                        push_byte(pick("aZ */(\"x"));
                    push_text("*/");
                end
                default:
                    push_byte(8'($urandom_range(0, 255)));
            endcase
            if ($urandom_range(0, 2) == 0)
                push_byte(GAPS[$urandom_range(0, 3)]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int ph;
        int base;

        // directed: byte extremes, every token kind, comments, end of text
        push_byte(8'h00);
        push_byte(8'hff);
        push_text("Z (\"Q\"\t+==");
        push_byte(CH_CR);
        push_text("//\n/*a**/<=");
        mark_end();
        push_cfg(1'b1);
        push_text("aB\"C");     // open string at end of text
        mark_end();
        push_text("//");        // dropped opener gives a bare end marker
        mark_end();

        // random texts, one register setting each
        base = n_queued;
        ph = 0;
        while (n_queued - base < RANDOM_BYTES)
        begin
            push_cfg(ph == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
            add_text($urandom_range(4, 14));
            mark_end();
            ph++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (text_q.size() != 0 || s_tvalid || token_beats_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Tokenized %0d text bytes in %0d texts (%0d with lower-casing on),",
                 n_bytes_in, n_texts, n_lc_bytes);
        $display("checked %0d result beats across %0d register writes.", n_beats_out, n_cfg);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of text beats with random gaps, writes when quiet
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= 8'h00;
            s_tlast     <= 1'b0;
            cfg_wr_en   <= 1'b0;
            cfg_wr_data <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_token_beats(s_tdata, s_tlast);
                n_bytes_in++;
                n_texts += s_tlast;
                n_lc_bytes += lc_shadow;
            end

            if (s_tvalid || m_tvalid || token_beats_q.size() != 0)
                quiet_cnt = 0;
            else if (quiet_cnt < CFG_SETTLE)
                quiet_cnt++;

            if (s_tvalid && !s_tready)
                cfg_wr_en <= 1'b0;      // hold the current beat
            else if (text_q.size() == 0)
            begin
                s_tvalid  <= 1'b0;
                cfg_wr_en <= 1'b0;
            end
            else if (text_q[0].is_cfg)
            begin
                s_tvalid <= 1'b0;
                if (quiet_cnt >= CFG_SETTLE && !s_tvalid && !cfg_wr_en &&
                    token_beats_q.size() == 0)
                begin
                    cfg_wr_en   <= 1'b1;
                    cfg_wr_data <= text_q[0].cfg_val;
                    lc_shadow = text_q[0].cfg_val;
                    n_cfg++;
                    void'(text_q.pop_front());
                end
                else
                    cfg_wr_en <= 1'b0;
            end
            else
            begin
                cfg_wr_en <= 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_q[0].ch;
                    s_tlast  <= text_q[0].eot;
                    void'(text_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result beat, stall on a changing pattern
    // ------------------------------------------------------------------
    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_beats_out++;
                if (token_beats_q.size() == 0)
                begin
                    $error("result beat with nothing expected: token_char %0h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    want_beat = token_beats_q.pop_front();
                    check_field("token_char", want_beat.ch, m_tdata);
                    check_field("char_valid", want_beat.valid, m_tuser[0]);
                    check_field("token_start", want_beat.start, m_tuser[1]);
                    check_field("token_kind", want_beat.kind, m_tuser[3:2]);
                    check_field("last_result", want_beat.last, m_tlast);
                    check_field("text_done", want_beat.done, m_tuser[4]);
                end
            end

            // pick a new stall behavior and pattern
            if (stall_cyc % 32 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_pat = 8'($urandom) | (8'h01 << $urandom_range(0, 7));
            end
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= stall_pat[stall_cyc[2:0]];
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
            stall_cyc++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no beat moving while work is still pending
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en ||
                (text_q.size() == 0 && !s_tvalid && token_beats_q.size() == 0))
                stuck_cnt <= 0;
            else if (stuck_cnt >= STUCK_LIMIT)
            begin
                $display("Timeout: no beat for %0d cycles", STUCK_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                stuck_cnt <= stuck_cnt + 1;
        end
    end

endmodule

/* source_text_tokenizer.f */
rtl/stt_pkg.sv
rtl/stt_scan.sv
rtl/source_text_tokenizer.sv
test/tb_top.sv
